// ----- design/fidps_pkg.sv -----
package fidps_pkg;

    // Probe progress
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_INIT_MFR,
        PH_INIT_DEV,
        PH_MFR,
        PH_MFR_EXT,
        PH_MFR_EXT3,
        PH_DEV,
        PH_DEV_EXT
    } t_phase;

    // Input transaction codes (tuser)
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_FAIL  = 2'd2
    } t_op;

    // Result transaction codes (tuser)
    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_DELAY  = 2'd2,
        KIND_FINISH = 2'd3
    } t_kind;

    localparam int ADDR_W  = 24;
    localparam int DELAY_W = 10;
    localparam int RADDR_W = 9;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_UNLOCK_ADDR_1 = 2'd0;
    localparam logic [1:0] REG_UNLOCK_ADDR_2 = 2'd1;
    localparam logic [1:0] REG_UNLOCK_DATA_1 = 2'd2;
    localparam logic [1:0] REG_UNLOCK_DATA_2 = 2'd3;

    // Flash command bytes and IDs
    localparam logic [7:0] CMD_LEGACY_A = 8'h80;
    localparam logic [7:0] CMD_LEGACY_B = 8'h60;
    localparam logic [7:0] CMD_STD      = 8'h90;
    localparam logic [7:0] RST_INTEL    = 8'hFF;
    localparam logic [7:0] RST_STD      = 8'hF0;
    localparam logic [7:0] ID_CONT      = 8'h7F;
    localparam logic [7:0] MFR_REENTER  = 8'hC2;
    localparam logic [7:0] MFR_INTEL    = 8'h89;

    localparam logic [DELAY_W-1:0] DELAY_ENTRY = 10'd50;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd1000;

    // Read offsets used by the probe
    localparam logic [RADDR_W-1:0] RA_ARRAY_0 = 9'h000;
    localparam logic [RADDR_W-1:0] RA_ARRAY_1 = 9'h001;
    localparam logic [RADDR_W-1:0] RA_MFR_EXT = 9'h100;
    localparam logic [RADDR_W-1:0] RA_MFR_X3  = 9'h003;
    localparam logic [RADDR_W-1:0] RA_DEV_EXT = 9'h101;

    // Unlock configuration
    typedef struct packed {
        logic [ADDR_W-1:0] addr_1;
        logic [ADDR_W-1:0] addr_2;
        logic [7:0]        data_1;
        logic [7:0]        data_2;
    } t_cfg;

    // One run of results: optional reset, optional ID entry, then a read or a finish
    typedef struct packed {
        logic               do_reset;
        logic [7:0]         reset_byte;
        logic               do_entry;
        logic               method;
        logic               is_finish;
        logic [RADDR_W-1:0] read_addr;
        logic               ok;
        logic               valid;
        logic [7:0]         mfr;
        logic [7:0]         dev;
    } t_run;

    // One result transaction
    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         wdata;
        logic [DELAY_W-1:0] delay;
        logic               ok;
        logic               valid;
        logic [7:0]         mfr;
        logic [7:0]         dev;
    } t_result;

endpackage

// ----- design/flash_id_probe_sequencer.sv -----
// Autoselect ID probe sequencer for a parallel NOR flash.
// Input stream (s_*): one transaction per event. tuser carries the op code
// (start, read data returned, access failure); tdata carries the ID method
// and the returned read byte. Output stream (m_*): bus requests (read, write,
// delay) and a final finish transaction holding both IDs and the flags;
// tlast marks the last result caused by one input transaction.
// An input transaction is decoded in the cycle it is taken and loads a run
// descriptor; the run is played out of a small step counter, one result per
// cycle into the output register. The run descriptor is registered on
// acceptance and the first result is then loaded from it into the output
// register. A run is one to ten results long (ten for a reenter with the
// legacy method); the next input is taken in the cycle that loads the last
// result of the run. Inputs that cause no result load no run.
// When the receiver stalls, the output register holds its result and the
// step counter waits; input stays blocked until the last result of the run
// has entered the output register.
// Reset clears the probe to idle, empties the output and loads the unlock
// registers with 0x5555, 0x2AAA, 0xAA and 0x55. The APB port reads and
// writes these four registers; pready is always high.
module flash_id_probe_sequencer
    import fidps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // method[0], read_data[8:1], zero[15:9]
    input  logic [1:0]  s_tuser,   // op[1:0]
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // bus_address[23:0], write_data[31:24], delay_micros[41:32], probe_ok[42],
    // id_valid[43], manufacturer_out[51:44], device_out[59:52], zero[63:60]
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // request_kind[1:0]
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    t_phase     r_phase;
    logic       r_method;
    logic [7:0] r_init_mfr;
    logic [7:0] r_init_dev;
    logic [7:0] r_mfr;
    logic [7:0] r_dev;

    t_phase     n_phase;
    logic       n_method;
    logic [7:0] n_init_mfr;
    logic [7:0] n_init_dev;
    logic [7:0] n_mfr;
    logic [7:0] n_dev;
    t_run       n_run;
    logic       n_run_has;

    logic       accept;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    logic [7:0] in_data;
    t_op        in_op;
    logic       take_ok;
    logic       out_valid;
    logic       out_last;
    t_result    out_res;

    // Run that reads a single offset
    function automatic t_run fn_read(logic [RADDR_W-1:0] a);
        t_run r;
        r           = '0;
        r.read_addr = a;
        return r;
    endfunction

    // Run after the manufacturer byte is known: reenter ID mode for one vendor
    function automatic t_run fn_after_mfr(logic [7:0] m, logic method);
        t_run r;
        r = fn_read(RA_ARRAY_1);
        if (m == MFR_REENTER) begin
            r.do_reset   = 1'b1;
            r.reset_byte = (m == MFR_INTEL) ? RST_INTEL : RST_STD;
            r.do_entry   = 1'b1;
            r.method     = method;
        end
        return r;
    endfunction

    // Run that resets the flash and reports both IDs
    function automatic t_run fn_finish(logic [7:0] m, logic [7:0] d,
                                       logic [7:0] im, logic [7:0] id);
        t_run r;
        r            = '0;
        r.do_reset   = 1'b1;
        r.reset_byte = (m == MFR_INTEL) ? RST_INTEL : RST_STD;
        r.is_finish  = 1'b1;
        r.ok         = 1'b1;
        r.valid      = ((m != im) || (d != id)) && (^m);
        r.mfr        = m;
        r.dev        = d;
        return r;
    endfunction

    assign in_op   = t_op'(s_tuser);
    assign in_data = s_tdata[8:1];
    assign accept  = s_tvalid && s_tready;

    // Decode one input transaction against the probe state
    always_comb begin
        n_phase    = r_phase;
        n_method   = r_method;
        n_init_mfr = r_init_mfr;
        n_init_dev = r_init_dev;
        n_mfr      = r_mfr;
        n_dev      = r_dev;
        n_run      = '0;
        n_run_has  = 1'b0;
        unique case (in_op)
            OP_START: begin
                n_method   = s_tdata[0];
                n_init_mfr = 8'd0;
                n_init_dev = 8'd0;
                n_mfr      = 8'd0;
                n_dev      = 8'd0;
                n_run      = fn_read(RA_ARRAY_0);
                n_run_has  = 1'b1;
                n_phase    = PH_INIT_MFR;
            end
            OP_FAIL: begin
                if (r_phase != PH_IDLE) begin
                    n_run.is_finish = 1'b1;
                    n_run.mfr       = r_mfr;
                    n_run.dev       = r_dev;
                    n_run_has       = 1'b1;
                    n_phase         = PH_IDLE;
                end
            end
            OP_DATA: begin
                unique case (r_phase)
                    PH_INIT_MFR: begin
                        n_init_mfr = in_data;
                        n_run      = fn_read(RA_ARRAY_1);
                        n_run_has  = 1'b1;
                        n_phase    = PH_INIT_DEV;
                    end
                    PH_INIT_DEV: begin
                        n_init_dev     = in_data;
                        n_run          = fn_read(RA_ARRAY_0);
                        n_run.do_entry = 1'b1;
                        n_run.method   = r_method;
                        n_run_has      = 1'b1;
                        n_phase        = PH_MFR;
                    end
                    PH_MFR, PH_MFR_EXT: begin
                        n_mfr     = in_data;
                        n_run_has = 1'b1;
                        if (in_data == ID_CONT) begin
                            n_run   = fn_read((r_phase == PH_MFR) ? RA_MFR_EXT : RA_MFR_X3);
                            n_phase = (r_phase == PH_MFR) ? PH_MFR_EXT : PH_MFR_EXT3;
                        end else begin
                            n_run   = fn_after_mfr(in_data, r_method);
                            n_phase = PH_DEV;
                        end
                    end
                    PH_MFR_EXT3: begin
                        n_mfr     = ID_CONT;
                        n_run     = fn_after_mfr(ID_CONT, r_method);
                        n_run_has = 1'b1;
                        n_phase   = PH_DEV;
                    end
                    PH_DEV: begin
                        n_dev     = in_data;
                        n_run_has = 1'b1;
                        if (in_data == ID_CONT) begin
                            n_run   = fn_read(RA_DEV_EXT);
                            n_phase = PH_DEV_EXT;
                        end else begin
                            n_run   = fn_finish(r_mfr, in_data, r_init_mfr, r_init_dev);
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_DEV_EXT: begin
                        n_dev     = in_data;
                        n_run     = fn_finish(r_mfr, in_data, r_init_mfr, r_init_dev);
                        n_run_has = 1'b1;
                        n_phase   = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Update the probe state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_method   <= 1'b0;
            r_init_mfr <= 8'd0;
            r_init_dev <= 8'd0;
            r_mfr      <= 8'd0;
            r_dev      <= 8'd0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_method   <= n_method;
            r_init_mfr <= n_init_mfr;
            r_init_dev <= n_init_dev;
            r_mfr      <= n_mfr;
            r_dev      <= n_dev;
        end
    end

    // Configuration registers
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.addr_1 <= 24'h005555;
            r_cfg.addr_2 <= 24'h002AAA;
            r_cfg.data_1 <= 8'hAA;
            r_cfg.data_2 <= 8'h55;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_UNLOCK_ADDR_1: r_cfg.addr_1 <= pwdata[ADDR_W-1:0];
                REG_UNLOCK_ADDR_2: r_cfg.addr_2 <= pwdata[ADDR_W-1:0];
                REG_UNLOCK_DATA_1: r_cfg.data_1 <= pwdata[7:0];
                default:           r_cfg.data_2 <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_UNLOCK_ADDR_1: prdata = {8'd0, r_cfg.addr_1};
            REG_UNLOCK_ADDR_2: prdata = {8'd0, r_cfg.addr_2};
            REG_UNLOCK_DATA_1: prdata = {24'd0, r_cfg.data_1};
            default:           prdata = {24'd0, r_cfg.data_2};
        endcase
    end

    // Play out runs into the output register
    fidps_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && n_run_has),
        .i_run       (n_run),
        .i_cfg       (r_cfg),
        .i_out_ready (m_tready),
        .o_take_ok   (take_ok),
        .o_out_valid (out_valid),
        .o_out_last  (out_last),
        .o_out       (out_res)
    );

    assign s_tready = take_ok;
    assign m_tvalid = out_valid;
    assign m_tlast  = out_last;
    assign m_tuser  = out_res.kind;
    assign m_tdata  = {4'd0, out_res.dev, out_res.mfr, out_res.valid, out_res.ok,
                       out_res.delay, out_res.wdata, out_res.addr};

endmodule

// ----- design/fidps_emit.sv -----
module fidps_emit
    import fidps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_run    i_run,
    input  t_cfg    i_cfg,
    input  logic    i_out_ready,
    output logic    o_take_ok,
    output logic    o_out_valid,
    output logic    o_out_last,
    output t_result o_out
);

    logic    r_busy;
    t_run    r_run;
    logic [3:0] r_pos;
    logic    r_out_valid;
    logic    r_out_last;
    t_result r_out;

    logic [3:0] rlen;
    logic [3:0] elen;
    logic [3:0] len;
    logic [3:0] q;
    logic [1:0] sub;
    logic [7:0] cmd;
    logic       adv;
    logic       at_last;
    t_result    n_out;

    // Work out the result for the current position in the run
    always_comb begin
        rlen  = r_run.do_reset ? 4'd2 : 4'd0;
        elen  = !r_run.do_entry ? 4'd0 : (r_run.method ? 4'd4 : 4'd7);
        len   = rlen + elen + 4'd1;
        q     = r_pos - rlen;
        sub   = (q >= 4'd3) ? 2'(q - 4'd3) : q[1:0];
        cmd   = r_run.method ? CMD_STD : ((q < 4'd3) ? CMD_LEGACY_A : CMD_LEGACY_B);
        n_out = '0;
        if (r_run.do_reset && (r_pos < 4'd2)) begin
            if (r_pos == 4'd0) begin
                n_out.kind  = KIND_WRITE;
                n_out.wdata = r_run.reset_byte;
            end else begin
                n_out.kind  = KIND_DELAY;
                n_out.delay = DELAY_RESET;
            end
        end else if (q < elen) begin
            if (q == elen - 4'd1) begin
                n_out.kind  = KIND_DELAY;
                n_out.delay = DELAY_ENTRY;
            end else begin
                n_out.kind = KIND_WRITE;
                unique case (sub)
                    2'd0: begin
                        n_out.addr  = i_cfg.addr_1;
                        n_out.wdata = i_cfg.data_1;
                    end
                    2'd1: begin
                        n_out.addr  = i_cfg.addr_2;
                        n_out.wdata = i_cfg.data_2;
                    end
                    default: begin
                        n_out.addr  = i_cfg.addr_1;
                        n_out.wdata = cmd;
                    end
                endcase
            end
        end else if (r_run.is_finish) begin
            n_out.kind  = KIND_FINISH;
            n_out.ok    = r_run.ok;
            n_out.valid = r_run.valid;
            n_out.mfr   = r_run.mfr;
            n_out.dev   = r_run.dev;
        end else begin
            n_out.kind = KIND_READ;
            n_out.addr = {{(ADDR_W-RADDR_W){1'b0}}, r_run.read_addr};
        end
    end

    assign adv       = r_busy && (!r_out_valid || i_out_ready);
    assign at_last   = (r_pos == len - 4'd1);
    assign o_take_ok = !r_busy || (adv && at_last);

    // Advance the run and hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= 4'd0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            if (adv) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
                r_out_last  <= at_last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_load) begin
                r_busy <= 1'b1;
                r_run  <= i_run;
                r_pos  <= 4'd0;
            end else if (adv) begin
                r_pos <= r_pos + 4'd1;
                if (at_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out       = r_out;

endmodule

// ----- design/fidps_chk.sv -----
module fidps_chk
    import fidps_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // A finish always closes its run
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == KIND_FINISH) |-> m_tlast)
        else $error("finish without tlast");

    // Flags only travel on a finish, and a valid ID needs a clean probe
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != KIND_FINISH) |-> (m_tdata[43:42] == 2'b00))
        else $error("flags on a bus request");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[43] |-> m_tdata[42])
        else $error("id_valid on aborted probe");

    // Output is empty after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind flash_id_probe_sequencer fidps_chk u_fidps_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
